// ===== rtl/rotary_encoder_value_adjust_top_macros.svh =====
// Assertion macros used by reva_core of the rotary encoder value adjuster RTL.
`ifndef ROTARY_ENCODER_VALUE_ADJUST_TOP_MACROS_SVH
`define ROTARY_ENCODER_VALUE_ADJUST_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define REVA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define REVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/reva_pkg.sv =====
// Shared types, codes and constants of the rotary encoder value adjuster.
package reva_pkg;

    localparam int CFG_VALUE_W = 11;
    localparam int CFG_TICKS_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int STEP_W      = 7;

    localparam int TARGET_RESET = 500;

    localparam logic [CFG_VALUE_W-1:0] VALUE_MIN_RESET = 11'd10;
    localparam logic [CFG_VALUE_W-1:0] VALUE_MAX_RESET = 11'd1000;
    localparam logic [CFG_TICKS_W-1:0] DEBOUNCE_RESET  = 8'd10;

    localparam logic [STEP_W-1:0] STEP_ONE     = 7'd1;
    localparam logic [STEP_W-1:0] STEP_TEN     = 7'd10;
    localparam logic [STEP_W-1:0] STEP_HUNDRED = 7'd100;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MIN      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MAX      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;

    typedef enum logic [1:0] {
        REQ_A_EDGE   = 2'd0,
        REQ_KEY_EDGE = 2'd1,
        REQ_TICK     = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_BAD_B  = 2'd1,
        ERR_NO_LOW = 2'd2
    } err_t;

    typedef struct packed {
        logic [CFG_VALUE_W-1:0] value_min;
        logic [CFG_VALUE_W-1:0] value_max;
        logic [CFG_TICKS_W-1:0] debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic value_changed;
        logic turn_seen;
        logic step_changed;
        err_t error_code;
    } flags_t;

    // Step sequence 1 -> 10 -> 100 -> 1; any other value returns to 1.
    function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        begin
            if (s == STEP_ONE)
            begin
                r = STEP_TEN;
            end
            else if (s == STEP_TEN)
            begin
                r = STEP_HUNDRED;
            end
            else
            begin
                r = STEP_ONE;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/reva_cfg.sv =====
// Configuration registers of the rotary encoder value adjuster.
module reva_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [reva_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [reva_pkg::CFG_VALUE_W-1:0]      cfg_data,
    output reva_pkg::cfg_t                        cfg
);

    reva_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_min      <= reva_pkg::VALUE_MIN_RESET;
            cfg_reg.value_max      <= reva_pkg::VALUE_MAX_RESET;
            cfg_reg.debounce_ticks <= reva_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                reva_pkg::REG_VALUE_MIN:
                begin
                    cfg_reg.value_min <= cfg_data;
                end
                reva_pkg::REG_VALUE_MAX:
                begin
                    cfg_reg.value_max <= cfg_data;
                end
                reva_pkg::REG_DEBOUNCE_TICKS:
                begin
                    cfg_reg.debounce_ticks <= cfg_data[reva_pkg::CFG_TICKS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/reva_core.sv =====
// Encoder and key decode state with the next-state logic for one word.
`include "rotary_encoder_value_adjust_top_macros.svh"

module reva_core #(
    parameter int VALUE_BITS = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic [1:0]                        req,
    input  logic                              a_level,
    input  logic                              b_level,
    input  logic                              key_level,
    input  reva_pkg::cfg_t                    cfg,
    output logic [VALUE_BITS-1:0]             target_next,
    output logic [reva_pkg::STEP_W-1:0]       step_next,
    output reva_pkg::flags_t                  flags
);

    // Compare width covers both the target and the 11-bit limits, plus a carry.
    localparam int CMP_W = ((VALUE_BITS > reva_pkg::CFG_VALUE_W) ?
                            VALUE_BITS : reva_pkg::CFG_VALUE_W) + 1;

    logic                            a_prev_reg,  a_prev_next;
    logic                            b_prev_reg,  b_prev_next;
    logic [VALUE_BITS-1:0]           target_reg;
    logic [reva_pkg::STEP_W-1:0]     step_reg;
    logic                            armed_reg,   armed_next;
    logic [reva_pkg::CFG_TICKS_W-1:0] tick_reg,   tick_next;

    logic [CMP_W-1:0]                inc_sum;
    logic [CMP_W-1:0]                dec_floor;
    logic [reva_pkg::CFG_TICKS_W-1:0] tick_inc;

    assign inc_sum   = CMP_W'(target_reg) + CMP_W'(step_reg);
    assign dec_floor = CMP_W'(cfg.value_min) + CMP_W'(step_reg);
    assign tick_inc  = tick_reg + reva_pkg::CFG_TICKS_W'(1);

    always_comb
    begin
        a_prev_next = a_prev_reg;
        b_prev_next = b_prev_reg;
        target_next = target_reg;
        step_next   = step_reg;
        armed_next  = armed_reg;
        tick_next   = tick_reg;
        flags       = '{value_changed: 1'b0, turn_seen: 1'b0, step_changed: 1'b0,
                        error_code: reva_pkg::ERR_NONE};
        case (req)
            reva_pkg::REQ_A_EDGE:
            begin
                if (a_level)
                begin
                    if (!a_prev_reg)
                    begin
                        if (!b_prev_reg && b_level)
                        begin
                            // Clockwise detent.
                            flags.turn_seen = 1'b1;
                            if (inc_sum <= CMP_W'(cfg.value_max))
                            begin
                                target_next         = inc_sum[VALUE_BITS-1:0];
                                flags.value_changed = 1'b1;
                            end
                        end
                        else if (b_prev_reg && !b_level)
                        begin
                            // Counterclockwise detent.
                            flags.turn_seen = 1'b1;
                            if (CMP_W'(target_reg) >= dec_floor)
                            begin
                                target_next         = target_reg - VALUE_BITS'(step_reg);
                                flags.value_changed = 1'b1;
                            end
                        end
                        else
                        begin
                            flags.error_code = reva_pkg::ERR_BAD_B;
                        end
                    end
                    else
                    begin
                        flags.error_code = reva_pkg::ERR_NO_LOW;
                    end
                end
                a_prev_next = a_level;
                b_prev_next = b_level;
            end
            reva_pkg::REQ_KEY_EDGE:
            begin
                armed_next = 1'b1;
            end
            reva_pkg::REQ_TICK:
            begin
                if (armed_reg)
                begin
                    tick_next = tick_inc;
                    // A limit of zero matches only after the counter wraps.
                    if (tick_inc == cfg.debounce_ticks)
                    begin
                        if (!key_level)
                        begin
                            step_next          = reva_pkg::next_step(step_reg);
                            flags.step_changed = 1'b1;
                        end
                        tick_next  = '0;
                        armed_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_prev_reg <= 1'b0;
            b_prev_reg <= 1'b0;
            target_reg <= VALUE_BITS'(reva_pkg::TARGET_RESET);
            step_reg   <= reva_pkg::STEP_ONE;
            armed_reg  <= 1'b0;
            tick_reg   <= '0;
        end
        else if (adv)
        begin
            a_prev_reg <= a_prev_next;
            b_prev_reg <= b_prev_next;
            target_reg <= target_next;
            step_reg   <= step_next;
            armed_reg  <= armed_next;
            tick_reg   <= tick_next;
        end
    end

    `REVA_ASSERT_IMP(a_step_legal, 1'b1, (step_reg == reva_pkg::STEP_ONE) || (step_reg == reva_pkg::STEP_TEN) || (step_reg == reva_pkg::STEP_HUNDRED), "step left the 1/10/100 cycle")
    `REVA_ASSERT_IMP(a_count_needs_arm, tick_reg != '0, armed_reg, "debounce count running while disarmed")
    `REVA_ASSERT_NEXT(a_target_only_on_turn, !adv || (req != reva_pkg::REQ_A_EDGE), $stable(target_reg), "target moved without an encoder word")
    `REVA_ASSERT_NEXT(a_press_disarms, adv && flags.step_changed, !armed_reg && (tick_reg == '0), "debounce not cleared after a step change")

endmodule

// ===== rtl/rotary_encoder_value_adjust_top.sv =====
// Top level of the rotary encoder value adjuster: stream ports, word pipeline, config port.
//
// The block decodes a two-phase rotary encoder with a push key. Each input word is an
// encoder A-pin edge, a key edge or a 1 ms tick (selected by s_axis_tuser). A clockwise
// detent raises the target by the current step and a counterclockwise detent lowers it,
// only while the result stays within value_min and value_max; a debounced key press
// cycles the step through 1, 10 and 100. Every input word yields exactly one output word
// carrying the target, the step, change flags and an error code. Throughput is one word
// per clock cycle while the output is not stalled: an input register feeds a single pass
// of decode logic that writes the output register, so a word is accepted while the
// previous result waits downstream. An accepted word waits in the input register until
// the output register is empty or is being drained, then moves into it.
// Configuration writes take effect at the next clock edge and must be made
// only while no word is in flight. After reset the target is 500 (masked to VALUE_BITS),
// the step is 1, and the limits are 10 and 1000 with a debounce of 10 ticks.
module rotary_encoder_value_adjust_top #(
    parameter int VALUE_BITS = 11
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, lowest bit first: a_level, b_level, key_level, zero fill.
    input  logic [7:0]                            s_axis_tdata,
    // tuser: req_type.
    input  logic [1:0]                            s_axis_tuser,
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata, lowest bit first: target_value (VALUE_BITS), step_size (7), value_changed,
    // turn_seen, step_changed, error_code (2), zero fill to whole bytes.
    output logic [((VALUE_BITS + 12 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [reva_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [reva_pkg::CFG_VALUE_W-1:0]      cfg_data
);

    localparam int RES_W  = VALUE_BITS + reva_pkg::STEP_W + 5;
    localparam int DATA_W = ((VALUE_BITS + 12 + 7) / 8) * 8;

    reva_pkg::cfg_t                 cfg;
    logic                           in_valid_reg;
    logic [1:0]                     in_req_reg;
    logic                           in_a_reg;
    logic                           in_b_reg;
    logic                           in_key_reg;
    logic                           out_valid_reg;
    logic [DATA_W-1:0]              out_data_reg;
    logic                           adv;
    logic [VALUE_BITS-1:0]          target_next;
    logic [reva_pkg::STEP_W-1:0]    step_next;
    reva_pkg::flags_t               flags;
    logic [RES_W-1:0]               result;

    // A word moves from the input register to the output register when the output
    // register is empty or is being drained in this cycle.
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;

    reva_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    reva_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .req         (in_req_reg),
        .a_level     (in_a_reg),
        .b_level     (in_b_reg),
        .key_level   (in_key_reg),
        .cfg         (cfg),
        .target_next (target_next),
        .step_next   (step_next),
        .flags       (flags)
    );

    assign result = {flags.error_code, flags.step_changed, flags.turn_seen,
                     flags.value_changed, step_next, target_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_reg <= s_axis_tuser;
            in_a_reg   <= s_axis_tdata[0];
            in_b_reg   <= s_axis_tdata[1];
            in_key_reg <= s_axis_tdata[2];
        end
        if (adv)
        begin
            out_data_reg <= DATA_W'(result);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
